// ----- design/n2d_pkg.sv -----
// Package for the NFA to DFA subset builder: sizes, function codes and item types.
package n2d_pkg;

	localparam int NfaStates = 8;
	localparam int Symbols = 2;
	localparam int MaxDfa = 255;

	typedef enum logic [2:0] {
		FUNC_LOAD_EPS  = 3'd0,
		FUNC_LOAD_MOVE = 3'd1,
		FUNC_BUILD     = 3'd2,
		FUNC_QUERY     = 3'd3,
		FUNC_RUN       = 3'd4
	} func_t;

	localparam logic REG_START = 1'b0;
	localparam logic REG_FINAL = 1'b1;

	typedef struct packed {
		logic [2:0] func;
		logic [2:0] nfa_state;
		logic       symbol;
		logic [7:0] target_mask;
		logic [7:0] dfa_state;
		logic       restart;
	} in_item_t;

	typedef struct packed {
		logic [7:0] dfa_count;
		logic [7:0] next_state;
		logic       next_exists;
		logic       next_accepting;
		logic [7:0] member_set;
		logic [7:0] run_state;
		logic       accepted;
		logic       dead;
	} out_item_t;

	// Closure step request and answer between the sequencer and the closure unit.
	typedef struct packed {
		logic       go;
		logic [7:0] seed;
	} clo_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] set;
	} clo_rsp_t;

endpackage

// ----- design/n2d_closure.sv -----
// Iterative epsilon closure unit: one widening pass over the epsilon table per cycle.
module n2d_closure (
	input  logic                clk,
	input  logic                arst_n,
	input  n2d_pkg::clo_req_t   req,
	input  logic [7:0]          eps [8],
	output n2d_pkg::clo_rsp_t   rsp
);
	import n2d_pkg::*;

	logic [7:0] set_q;
	logic       busy_q;
	logic [7:0] grown;

	always_comb begin
		grown = set_q;
		for (int s = 0; s < NfaStates; s++) begin
			if (set_q[s]) begin
				grown = grown | eps[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.go) begin
			busy_q <= 1'b1;
		end else if (busy_q && grown == set_q) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			set_q <= req.seed;
		end else if (busy_q) begin
			set_q <= grown;
		end
	end

	assign rsp.done = busy_q && (grown == set_q);
	assign rsp.set  = set_q;
endmodule

// ----- design/nfa_to_dfa_subset_builder_unit.sv -----
// Top level of the NFA to DFA subset builder: tables, build sequencer and run logic.
// Loads, queries and run steps that do not move pass through READ and FINISH before the
// result strobe; a run step that moves passes through both twice to reread the new state.
// A build clears all 256 entries of the set-to-id map, then for each DFA state and symbol
// steps through FETCH, MOVE, the closure passes, SEED and LOOK, and ends via ENTER.
// One item at a time: busy stays high from acceptance to the strobe; reset (arst_n low)
// clears the epsilon and move tables, run state and build count; final_q resets to 4.
module nfa_to_dfa_subset_builder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  n2d_pkg::in_item_t    item,
	output logic                 done,
	output n2d_pkg::out_item_t   result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);
	import n2d_pkg::*;

	// Sequencer states. The simple functions pass through READ and FINISH;
	// a build clears the map, then alternates move, closure and lookup steps.
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_READ   = 10'b0000000010,
		ST_FINISH = 10'b0000000100,
		ST_CLEAR  = 10'b0000001000,
		ST_SEED   = 10'b0000010000,
		ST_CLO    = 10'b0000100000,
		ST_LOOK   = 10'b0001000000,
		ST_ENTER  = 10'b0010000000,
		ST_FETCH  = 10'b0100000000,
		ST_MOVE   = 10'b1000000000
	} state_t;

	state_t state_q;
	in_item_t item_q;

	logic [2:0] start_q;
	logic [7:0] final_q;
	logic [7:0] eps_q [8];
	logic [7:0] move_q [16];

	// Memories: DFA sets, transitions and the set-to-id map.
	logic [7:0] sets_mem [256];
	logic [8:0] trans_mem [512];
	logic [8:0] map_mem [256];
	logic [7:0] sets_rd_q;
	logic [8:0] trans_rd_q;
	logic [8:0] map_rd_q;

	logic [8:0] total_q;
	logic [7:0] run_q;
	logic       dead_q;
	// NFA set of the current run position, kept so any item can report acceptance.
	logic [7:0] run_set_q;

	logic [7:0] cur_q;
	logic       sym_q;
	logic [7:0] clear_q;
	logic       first_q;
	logic [7:0] cset_q;

	clo_req_t clo_req;
	clo_rsp_t clo_rsp;

	n2d_closure u_closure (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (clo_req),
		.eps   (eps_q),
		.rsp   (clo_rsp)
	);

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 3'd0;
			final_q <= 8'd4;
		end else if (cfg_valid) begin
			if (cfg_index == REG_START) begin
				start_q <= cfg_data[2:0];
			end else begin
				final_q <= cfg_data;
			end
		end
	end

	// Move of the current DFA set on the current symbol, from the fetched set.
	logic [7:0] moved;
	always_comb begin
		moved = '0;
		for (int s = 0; s < NfaStates; s++) begin
			if (sets_rd_q[s]) begin
				moved = moved | move_q[s * Symbols + int'(sym_q)];
			end
		end
	end

	// Read addresses chosen by the sequencer. A run step with restart reads
	// the transition out of DFA state 0.
	logic [7:0] sets_ra;
	logic [8:0] trans_ra;
	always_comb begin
		if (state_q == ST_READ) begin
			sets_ra  = (item_q.func == FUNC_QUERY) ? item_q.dfa_state : run_q;
			trans_ra = (item_q.func == FUNC_QUERY) ? {item_q.dfa_state, item_q.symbol}
			                                       : {(item_q.restart ? 8'd0 : run_q),
			                                          item_q.symbol};
		end else begin
			sets_ra  = cur_q;
			trans_ra = {cur_q, sym_q};
		end
	end

	always_ff @(posedge clk) begin
		sets_rd_q  <= sets_mem[sets_ra];
		trans_rd_q <= trans_mem[trans_ra];
		map_rd_q   <= map_mem[clo_rsp.set];
	end

	// Lookup of the closed set happens in ST_LOOK (map data valid then).
	logic       new_set;
	logic [8:0] entry;
	always_comb begin
		new_set = 1'b0;
		entry   = '0;
		if (cset_q != 8'd0) begin
			if (map_rd_q[8]) begin
				entry = map_rd_q;
			end else if (total_q < 9'(MaxDfa)) begin
				new_set = 1'b1;
				entry   = {1'b1, total_q[7:0]};
			end
		end
	end

	// Run step evaluated in ST_FINISH from the start-of-item run state.
	logic       run_live;
	logic [7:0] run_pos;
	logic       tr_ok;
	always_comb begin
		run_pos  = (item_q.restart) ? 8'd0 : run_q;
		run_live = item_q.restart || !dead_q;
		tr_ok    = ({1'b0, run_pos} < total_q) && trans_rd_q[8];
	end

	// Result item formed in ST_FINISH. After a build or a moving run step the
	// fetched set is the one of the new run position; otherwise the kept set is used.
	logic [7:0] acc_set;
	out_item_t  fin_res;
	always_comb begin
		acc_set = (item_q.func == FUNC_BUILD) ? sets_rd_q : run_set_q;
		fin_res = '0;
		fin_res.dfa_count = total_q[7:0];
		fin_res.run_state = run_q;
		fin_res.dead      = dead_q;
		fin_res.accepted  = !dead_q && ({1'b0, run_q} < total_q) &&
		                    ((acc_set & final_q) != 8'd0);
		if (item_q.func == FUNC_QUERY && ({1'b0, item_q.dfa_state} < total_q)) begin
			fin_res.member_set     = sets_rd_q;
			fin_res.next_accepting = (sets_rd_q & final_q) != 8'd0;
			fin_res.next_exists    = trans_rd_q[8];
			fin_res.next_state     = trans_rd_q[8] ? trans_rd_q[7:0] : 8'd0;
		end
		if (item_q.func == FUNC_RUN && run_live && !tr_ok) begin
			fin_res.run_state = run_pos;
			fin_res.dead      = 1'b1;
			fin_res.accepted  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			map_mem[clear_q] <= '0;
		end else if (state_q == ST_LOOK && (new_set || first_q)) begin
			map_mem[cset_q] <= {1'b1, total_q[7:0]};
		end
		if (state_q == ST_LOOK && (new_set || first_q)) begin
			sets_mem[total_q[7:0]] <= cset_q;
		end
		if (state_q == ST_LOOK && !first_q) begin
			trans_mem[{cur_q, sym_q}] <= entry;
		end
		if (clo_rsp.done) begin
			cset_q <= clo_rsp.set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			item_q    <= '0;
			total_q   <= '0;
			run_q     <= '0;
			dead_q    <= 1'b0;
			run_set_q <= '0;
			cur_q     <= '0;
			sym_q     <= 1'b0;
			clear_q   <= '0;
			first_q   <= 1'b0;
			done      <= 1'b0;
			result    <= '0;
			clo_req   <= '0;
			for (int i = 0; i < 8; i++) begin
				eps_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) begin
				move_q[i] <= '0;
			end
		end else begin
			done    <= 1'b0;
			clo_req <= '0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_q <= item;
						if (item.func == FUNC_BUILD) begin
							clear_q <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					case (item_q.func)
						FUNC_LOAD_EPS: begin
							eps_q[item_q.nfa_state] <= item_q.target_mask;
						end
						FUNC_LOAD_MOVE: begin
							move_q[{item_q.nfa_state, item_q.symbol}] <= item_q.target_mask;
						end
						FUNC_BUILD: begin
							run_set_q <= sets_rd_q;
						end
						FUNC_RUN: begin
							if (run_live) begin
								if (tr_ok) begin
									run_q <= trans_rd_q[7:0];
									dead_q <= 1'b0;
									item_q.func <= FUNC_BUILD;
								end else begin
									run_q <= run_pos;
									dead_q <= 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
					// A successful run step rereads the new position for acceptance.
					if (item_q.func == FUNC_RUN && run_live && tr_ok) begin
						state_q <= ST_READ;
					end else begin
						result  <= fin_res;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clear_q <= clear_q + 8'd1;
					if (clear_q == 8'd255) begin
						total_q <= '0;
						first_q <= 1'b1;
						clo_req.go <= 1'b1;
						clo_req.seed <= 8'd1 << start_q;
						state_q <= ST_CLO;
					end
				end
				ST_CLO: begin
					if (clo_rsp.done) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					// Map read of the closed set lands this cycle.
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (first_q || new_set) begin
						total_q <= total_q + 9'd1;
					end
					if (first_q) begin
						first_q <= 1'b0;
						cur_q <= '0;
						sym_q <= 1'b0;
						state_q <= ST_FETCH;
					end else if (sym_q == 1'b0) begin
						sym_q <= 1'b1;
						state_q <= ST_FETCH;
					end else if ({1'b0, cur_q} + 9'd1 < total_q + {8'd0, new_set}) begin
						cur_q <= cur_q + 8'd1;
						sym_q <= 1'b0;
						state_q <= ST_FETCH;
					end else begin
						run_q <= '0;
						dead_q <= 1'b0;
						state_q <= ST_ENTER;
					end
				end
				ST_FETCH: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					clo_req.go <= 1'b1;
					clo_req.seed <= moved;
					state_q <= ST_CLO;
				end
				ST_ENTER: begin
					// Build result; rereads state 0 for acceptance via READ.
					item_q.func <= FUNC_BUILD;
					state_q <= ST_READ;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
